FILE: rtl/core/lcts_pkg.sv
// Package for the link class traffic statistics core.
// Holds widths, reset constants, event kind codes and controller/datapath command types.
// No dependencies.
package lcts_pkg;

	localparam int CLASS_COUNT          = 4;
	localparam int CLS_W                = 2;
	localparam int BYTE_COUNT_WIDTH_DEF = 48;

	localparam int WEIGHT_W  = 9;
	localparam int LAT_W     = 28;
	localparam int THR_W     = 32;
	localparam int LOSS_W    = 15;
	localparam int CNT_W     = 32;
	localparam int TIME_W    = 32;
	localparam int BYTES_W   = 16;
	localparam int RTT_W     = 20;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd230;
	localparam logic [LOSS_W-1:0]   LOSS_MAX     = 15'd25600;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LOSS = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	// Command from controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic apply_evt; // apply data or loss event to all masked classes
		logic tick_chk;  // compare time, latch time delta
		logic cls_start; // load class operands, start dividers
		logic cls_fin;   // blend and store results for current class
		logic tick_end;  // commit last tick time
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_tick;   // captured kind is a tick
		logic time_same; // tick at unchanged time
		logic div_done;  // both dividers finished
	} dp_sts_t;

	// Blend: (w*old + (256-w)*sample + 128) >> 8, weight clamped to 256; the caller saturates to width
	function automatic logic [32:0] blend(input logic [WEIGHT_W-1:0] w_raw,
			input logic [31:0] old_v, input logic [31:0] smp);
		logic [8:0]  w;
		logic [41:0] acc;
		begin
			w   = (w_raw > 9'd256) ? 9'd256 : w_raw;
			acc = 42'(w) * 42'(old_v) + 42'(9'd256 - w) * 42'(smp) + 42'd128;
			blend = acc[40:8];
		end
	endfunction

endpackage

FILE: rtl/core/lcts_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Does not use lcts_pkg; widths are given by parameters.
// Standalone, no dependencies.
module lcts_divider #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};

	// Shift in one numerator bit and subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quo  = quo_q;
	assign rem  = rem_q[DEN_W-1:0];

endmodule

FILE: rtl/core/lcts_ctrl.sv
// Controller state machine for the traffic statistics core.
// Depends on lcts_pkg for command and status types.
// Sequences events, ticks over classes and the result handshake.
module lcts_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lcts_pkg::CLS_W-1:0]  cls_idx,
	output lcts_pkg::dp_cmd_t           cmd,
	input  lcts_pkg::dp_sts_t           sts
);

	localparam int IDX_W = lcts_pkg::CLS_W;
	localparam int NCLS  = lcts_pkg::CLASS_COUNT;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_START, ST_WAIT, ST_FIN, ST_OUT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cls_idx   = idx_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.apply_evt = (state_q == ST_DECODE) && !sts.is_tick;
		cmd.tick_chk  = (state_q == ST_DECODE) && sts.is_tick;
		cmd.cls_start = (state_q == ST_START);
		cmd.cls_fin   = (state_q == ST_FIN);
		cmd.tick_end  = (state_q == ST_OUT) && out_ready && (idx_q == IDX_W'(NCLS - 1));
	end

	// Advance state; one class per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					idx_q <= '0;
					if (sts.is_tick && !sts.time_same)
						state_q <= ST_START;
					else
						state_q <= ST_IDLE;
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sts.div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) begin
						if (idx_q == IDX_W'(NCLS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output offered only after a class is finished
	a_out_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN)) else $error("result without finish");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept during output");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(NCLS - 1)) else $error("class index out of range");

endmodule

FILE: rtl/core/lcts_datapath.sv
// Datapath for the traffic statistics core: counters, averages and dividers.
// Depends on lcts_pkg and lcts_divider.
// Driven by command signals from lcts_ctrl.
module lcts_datapath #(
	parameter int BYTE_COUNT_WIDTH = lcts_pkg::BYTE_COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lcts_pkg::WEIGHT_W-1:0]     weight,
	input  logic [1:0]                        kind,
	input  logic [3:0]                        class_mask,
	input  logic [lcts_pkg::BYTES_W-1:0]      packet_bytes,
	input  logic [lcts_pkg::RTT_W-1:0]        round_trip,
	input  logic [lcts_pkg::TIME_W-1:0]       time_now,
	input  logic [lcts_pkg::CLS_W-1:0]        cls_idx,
	input  lcts_pkg::dp_cmd_t                 cmd,
	output lcts_pkg::dp_sts_t                 sts,
	output logic [lcts_pkg::LAT_W-1:0]        smoothed_latency,
	output logic [lcts_pkg::THR_W-1:0]        smoothed_throughput,
	output logic [lcts_pkg::LOSS_W-1:0]       smoothed_loss
);

	localparam int NC    = lcts_pkg::CLASS_COUNT;
	localparam int BW    = BYTE_COUNT_WIDTH;
	localparam int IDX_W = lcts_pkg::CLS_W;
	localparam int LN_W  = 47; // losses * 25600 fits in 47 bits

	logic [1:0]                     kind_q;
	logic [3:0]                     mask_q;
	logic [lcts_pkg::BYTES_W-1:0]   bytes_q;
	logic [lcts_pkg::RTT_W-1:0]     rtt_q;
	logic [lcts_pkg::TIME_W-1:0]    now_q;
	logic [lcts_pkg::TIME_W-1:0]    last_time_q;
	logic [lcts_pkg::TIME_W-1:0]    delta_q;

	logic [lcts_pkg::CNT_W-1:0]     pkt_q  [NC];
	logic [BW-1:0]                  byte_q [NC];
	logic [lcts_pkg::CNT_W-1:0]     loss_q [NC];
	logic [1:0]                     idle_q [NC];
	logic [lcts_pkg::LAT_W-1:0]     lat_q  [NC];
	logic [lcts_pkg::THR_W-1:0]     thr_q  [NC];
	logic [lcts_pkg::LOSS_W-1:0]    lavg_q [NC];

	logic [IDX_W-1:0]               ci;
	logic                           loss_zero_q;
	logic [BW-1:0]                  tq;
	logic [63:0]                    tq_ext;
	logic [31:0]                    tr;
	logic [LN_W-1:0]                lq;
	logic [31:0]                    lr;
	logic                           tdone, ldone;
	logic [BW-1:0]                  div_num;
	logic [LN_W-1:0]                loss_num;
	logic [32:0]                    thr_smp, thr_new, loss_new;
	logic [LN_W-1:0]                loss_smp;

	assign ci = cls_idx;

	assign sts.is_tick   = (kind_q == lcts_pkg::KIND_TICK);
	assign sts.time_same = (now_q == last_time_q);
	assign sts.div_done  = tdone && ldone;

	assign div_num  = byte_q[ci];
	assign loss_num = LN_W'(loss_q[ci]) * LN_W'(lcts_pkg::LOSS_MAX);
	assign tq_ext   = 64'(tq);

	lcts_divider #(.NUM_W(BW), .DEN_W(32)) u_thr_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.cls_start),
		.num(div_num), .den(delta_q), .done(tdone), .quo(tq), .rem(tr)
	);

	lcts_divider #(.NUM_W(LN_W), .DEN_W(32)) u_loss_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.cls_start),
		.num(loss_num), .den(pkt_q[ci] == '0 ? 32'd1 : pkt_q[ci]),
		.done(ldone), .quo(lq), .rem(lr)
	);

	// Throughput sample: 2q + (2r >= d), saturating
	always_comb begin
		if (tq_ext > 64'h0000_0000_FFFF_FFFF) begin
			thr_smp = 33'h0_FFFF_FFFF;
		end else begin
			thr_smp = {tq_ext[31:0], 1'b0} + 33'({1'b0, tr, 1'b0} >= {2'b0, delta_q});
			if (thr_smp > 33'h0_FFFF_FFFF)
				thr_smp = 33'h0_FFFF_FFFF;
		end
		loss_smp = loss_zero_q ? '0 :
			((lq > LN_W'(lcts_pkg::LOSS_MAX)) ? LN_W'(lcts_pkg::LOSS_MAX) : lq);
		thr_new  = lcts_pkg::blend(weight, 32'(thr_q[ci]), thr_smp[31:0]);
		loss_new = lcts_pkg::blend(weight, 32'(lavg_q[ci]), 32'(loss_smp));
	end

	// Capture input item, time delta and zero-loss flag
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			mask_q  <= class_mask;
			bytes_q <= packet_bytes;
			rtt_q   <= round_trip;
			now_q   <= time_now;
		end
		if (cmd.tick_chk)
			delta_q <= now_q - last_time_q;
		if (cmd.cls_start)
			loss_zero_q <= (loss_q[ci] == '0) || (pkt_q[ci] == '0);
	end

	// Per-class state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			for (int c = 0; c < NC; c++) begin
				pkt_q[c]  <= '0;
				byte_q[c] <= '0;
				loss_q[c] <= '0;
				idle_q[c] <= '0;
				lat_q[c]  <= '0;
				thr_q[c]  <= '0;
				lavg_q[c] <= '0;
			end
		end else begin
			if (cmd.tick_end)
				last_time_q <= now_q;
			for (int c = 0; c < NC; c++) begin
				if (cmd.apply_evt && mask_q[c]) begin
					if (kind_q == lcts_pkg::KIND_DATA) begin
						logic [32:0] ln;
						logic [BW:0] bsum;
						if (pkt_q[c] != '1)
							pkt_q[c] <= pkt_q[c] + 1'b1;
						bsum = {1'b0, byte_q[c]} + (BW+1)'(bytes_q);
						byte_q[c] <= bsum[BW] ? '1 : bsum[BW-1:0];
						ln = lcts_pkg::blend(weight, 32'(lat_q[c]), {4'd0, rtt_q, 8'd0});
						lat_q[c]  <= (ln > 33'h0FFF_FFFF) ? '1 : ln[27:0];
						idle_q[c] <= '0;
					end else if (kind_q == lcts_pkg::KIND_LOSS) begin
						if (loss_q[c] != '1)
							loss_q[c] <= loss_q[c] + 1'b1;
					end
				end
				if (cmd.cls_fin && ci == IDX_W'(c)) begin
					thr_q[c]  <= (thr_new > 33'h0_FFFF_FFFF) ? '1 : thr_new[31:0];
					lavg_q[c] <= (loss_new > 33'(lcts_pkg::LOSS_MAX)) ?
						lcts_pkg::LOSS_MAX : loss_new[14:0];
					if (idle_q[c] != 2'd0)
						lat_q[c] <= '0;
					if (idle_q[c] < 2'd2)
						idle_q[c] <= idle_q[c] + 1'b1;
					pkt_q[c]  <= '0;
					byte_q[c] <= '0;
					loss_q[c] <= '0;
				end
			end
		end
	end

	assign smoothed_latency    = lat_q[ci];
	assign smoothed_throughput = thr_q[ci];
	assign smoothed_loss       = lavg_q[ci];

	a_loss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lavg_q[0] <= lcts_pkg::LOSS_MAX) else $error("loss average above limit");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cls_fin |=> pkt_q[$past(ci)] == '0) else $error("counter not cleared");
	a_idle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idle_q[0] != 2'd3) else $error("idle count out of range");

endmodule

FILE: rtl/core/link_class_traffic_stats_core.sv
// Link class traffic statistics core, top level.
// A data, loss or ignored event goes through decode back to idle; a tick at a new time
// runs, per class, a start, a wait on two bit-serial dividers, a finish and the result
// transfer. No new event is accepted until the previous one and its results are done.
// A tick emits its four results one after another.
// Reset (arst_n low) clears all counters and averages, weight returns to 230.
module link_class_traffic_stats_core #(
	parameter int BYTE_COUNT_WIDTH = lcts_pkg::BYTE_COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // class_mask[3:0], packet_bytes[19:4],
	                              // round_trip[39:20], time_now[71:40]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // smoothed_latency[27:0], smoothed_throughput[59:28],
	                              // smoothed_loss[74:60]
	output logic [1:0]  m_tuser,  // class_id[1:0]
	output logic        m_tlast
);

	localparam int IDX_W = lcts_pkg::CLS_W;

	logic [lcts_pkg::WEIGHT_W-1:0] weight_q;
	logic [IDX_W-1:0]              cls_idx;
	lcts_pkg::dp_cmd_t             cmd;
	lcts_pkg::dp_sts_t             sts;
	logic [lcts_pkg::LAT_W-1:0]    lat;
	logic [lcts_pkg::THR_W-1:0]    thr;
	logic [lcts_pkg::LOSS_W-1:0]   loss;

	// Hold configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			weight_q <= lcts_pkg::WEIGHT_RESET;
		else if (cfg_we)
			weight_q <= cfg_wdata;
	end

	lcts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .cls_idx(cls_idx),
		.cmd(cmd), .sts(sts)
	);

	lcts_datapath #(.BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .weight(weight_q),
		.kind(s_tuser), .class_mask(s_tdata[3:0]), .packet_bytes(s_tdata[19:4]),
		.round_trip(s_tdata[39:20]), .time_now(s_tdata[71:40]),
		.cls_idx(cls_idx), .cmd(cmd), .sts(sts),
		.smoothed_latency(lat), .smoothed_throughput(thr), .smoothed_loss(loss)
	);

	assign m_tdata = {5'd0, loss, thr, lat};
	assign m_tuser = cls_idx;
	assign m_tlast = (cls_idx == IDX_W'(lcts_pkg::CLASS_COUNT - 1));

endmodule
